/* design/gsch_pkg.sv */
// Shared types and constants for the Graham-scan hull block.
// Depends on nothing; imported by every module of the block.
package gsch_pkg;

    localparam int CB             = 16;
    localparam int MAX_POINTS_DEF = 64;

    typedef struct packed {
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
        logic                 final_point;
    } t_in_item;

    typedef struct packed {
        logic signed [CB-1:0] hull_x;
        logic signed [CB-1:0] hull_y;
        logic                 hull_last;
    } t_out_item;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
    } t_point;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_turn;

endpackage

/* design/gsch_cross.sv */
// Shared cross-product sign unit: sign of cross(a - o, b - o), exact.
// Two register stages (differences, products); uses gsch_pkg.
module gsch_cross import gsch_pkg::*; (
    input  logic   i_clk,
    input  t_point i_o,
    input  t_point i_a,
    input  t_point i_b,
    output t_turn  o_turn
);

    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int QW = PW + 1;

    logic signed [DW-1:0] r_dxa, r_dyb, r_dya, r_dxb;
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [QW-1:0] w_diff;

    always_ff @(posedge i_clk) begin
        r_dxa <= DW'(i_a.x) - DW'(i_o.x);
        r_dyb <= DW'(i_b.y) - DW'(i_o.y);
        r_dya <= DW'(i_a.y) - DW'(i_o.y);
        r_dxb <= DW'(i_b.x) - DW'(i_o.x);
        r_p1  <= PW'(r_dxa) * PW'(r_dyb);
        r_p2  <= PW'(r_dya) * PW'(r_dxb);
    end

    assign w_diff      = QW'(r_p1) - QW'(r_p2);
    assign o_turn.neg  = w_diff[QW-1];
    assign o_turn.zero = (w_diff == '0);

endmodule

/* design/graham_scan_convex_hull.sv */
// Operation: points load one per cycle while idle; a final item starts the run, which finds the
// minimum, then does insertion-sort steps, ray checks and scan tests through the shared
// cross-product unit; hull vertices then leave one at a time, holding while the output is stalled.
// Throughput: one hull at a time; no input is taken while the run is in progress.
// Reset: sequencer, counters and output valid clear; point store stays undefined.
module graham_scan_convex_hull import gsch_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int SW = 5;

    localparam logic [SW-1:0] ST_LOAD = 5'd0,  ST_WAIT = 5'd1,  ST_MIN_SET = 5'd2,
        ST_MIN_USE = 5'd3,   ST_SORT_RD = 5'd4,  ST_SORT_P = 5'd5,   ST_SORT_J = 5'd6,
        ST_SORT_OQ = 5'd7,   ST_SORT_Q = 5'd8,   ST_SORT_CMP = 5'd9, ST_DED_START = 5'd10,
        ST_DED_O = 5'd11,    ST_DED_U = 5'd12,   ST_DED_LOOP = 5'd13, ST_DED_O2 = 5'd14,
        ST_DED_V = 5'd15,    ST_DED_CMP = 5'd16, ST_SCAN_START = 5'd17, ST_SCAN_T = 5'd18,
        ST_SCAN_NEXT = 5'd19, ST_SCAN_V = 5'd20, ST_SCAN_POP = 5'd21, ST_SCAN_B = 5'd22,
        ST_SCAN_TST = 5'd23, ST_EMIT_RD = 5'd24, ST_EMIT_W = 5'd25;

    logic [SW-1:0] r_state, n_state, r_ret, n_ret;
    logic          r_wc, n_wc;
    logic [CW-1:0] r_n, n_n, r_i, n_i, r_j, n_j, r_cnt, n_cnt, r_m, n_m, r_s, n_s;
    logic [AW-1:0] r_pa, n_pa, r_oa, n_oa, r_ra, n_ra, r_qi, n_qi;
    t_point        r_org, n_org, r_p, n_p, r_u, n_u, r_v, n_v, r_top, n_top;
    t_point        r_below, n_below, r_xo, n_xo, r_xa, n_xa, r_xb, n_xb;
    logic          r_ov, n_ov;
    t_out_item     r_out, n_out;

    t_point        pts_mem [MAX_POINTS];
    logic [AW-1:0] ord_mem [MAX_POINTS];
    t_point        ray_mem [MAX_POINTS];
    t_point        r_pq, r_rq;
    logic [AW-1:0] r_oq;

    logic          pwe, owe, rwe;
    logic [AW-1:0] pwa, owa, rwa, owd;
    t_point        pwd, rwd;
    t_turn         w_turn;
    logic          w_acc, w_before;

    gsch_cross u_cross (
        .i_clk (i_clk),
        .i_o   (r_xo),
        .i_a   (r_xa),
        .i_b   (r_xb),
        .o_turn(w_turn)
    );

    always_ff @(posedge i_clk) begin
        if (pwe) pts_mem[pwa] <= pwd;
        if (owe) ord_mem[owa] <= owd;
        if (rwe) ray_mem[rwa] <= rwd;
        r_pq <= pts_mem[r_pa];
        r_oq <= ord_mem[r_oa];
        r_rq <= ray_mem[r_ra];
    end

    assign o_in_stall  = (r_state != ST_LOAD);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    always_comb begin
        if (!w_turn.zero)
            w_before = !w_turn.neg;
        else if (r_p.x != r_xb.x)
            w_before = r_p.x < r_xb.x;
        else
            w_before = r_p.y < r_xb.y;
    end

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_wc = r_wc;
        n_n = r_n; n_i = r_i; n_j = r_j; n_cnt = r_cnt; n_m = r_m; n_s = r_s;
        n_pa = r_pa; n_oa = r_oa; n_ra = r_ra; n_qi = r_qi;
        n_org = r_org; n_p = r_p; n_u = r_u; n_v = r_v; n_top = r_top; n_below = r_below;
        n_xo = r_xo; n_xa = r_xa; n_xb = r_xb;
        n_ov = r_ov; n_out = r_out;
        pwe = 1'b0; pwa = r_n[AW-1:0]; pwd = '{x: i_in_item.px, y: i_in_item.py};
        owe = 1'b0; owa = r_j[AW-1:0]; owd = r_i[AW-1:0];
        rwe = 1'b0; rwa = r_m[AW-1:0]; rwd = r_u;

        if (r_ov && !i_out_stall) n_ov = 1'b0;

        unique case (r_state)
            ST_LOAD: begin
                if (w_acc) begin
                    if (r_n < CW'(MAX_POINTS)) begin
                        pwe = 1'b1;
                        n_n = r_n + CW'(1);
                    end
                    if (i_in_item.final_point) begin
                        n_i = '0;
                        n_state = ST_MIN_SET;
                    end
                end
            end
            ST_WAIT: begin
                if (r_wc) n_wc = 1'b0;
                else n_state = r_ret;
            end
            ST_MIN_SET: begin
                n_pa = r_i[AW-1:0];
                n_wc = 1'b0; n_ret = ST_MIN_USE; n_state = ST_WAIT;
            end
            ST_MIN_USE: begin
                if (r_i == '0 || r_pq.x < r_org.x || (r_pq.x == r_org.x && r_pq.y < r_org.y))
                    n_org = r_pq;
                if ((r_i + CW'(1)) < r_n) begin
                    n_i = r_i + CW'(1);
                    n_state = ST_MIN_SET;
                end else begin
                    n_i = '0; n_cnt = '0;
                    n_state = ST_SORT_RD;
                end
            end
            ST_SORT_RD: begin
                n_pa = r_i[AW-1:0];
                n_wc = 1'b0; n_ret = ST_SORT_P; n_state = ST_WAIT;
            end
            ST_SORT_P: begin
                n_p = r_pq;
                if (r_pq == r_org) begin
                    if ((r_i + CW'(1)) < r_n) begin
                        n_i = r_i + CW'(1); n_state = ST_SORT_RD;
                    end else n_state = ST_DED_START;
                end else begin
                    n_j = r_cnt;
                    n_state = ST_SORT_J;
                end
            end
            ST_SORT_J: begin
                if (r_j == '0) begin
                    owe = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                    if ((r_i + CW'(1)) < r_n) begin
                        n_i = r_i + CW'(1); n_state = ST_SORT_RD;
                    end else n_state = ST_DED_START;
                end else begin
                    n_oa = AW'(r_j - CW'(1));
                    n_wc = 1'b0; n_ret = ST_SORT_OQ; n_state = ST_WAIT;
                end
            end
            ST_SORT_OQ: begin
                n_pa = r_oq; n_qi = r_oq;
                n_wc = 1'b0; n_ret = ST_SORT_Q; n_state = ST_WAIT;
            end
            ST_SORT_Q: begin
                n_xo = r_org; n_xa = r_p; n_xb = r_pq;
                n_wc = 1'b1; n_ret = ST_SORT_CMP; n_state = ST_WAIT;
            end
            ST_SORT_CMP: begin
                owe = 1'b1;
                if (w_before) begin
                    owd = r_qi;
                    n_j = r_j - CW'(1);
                    n_state = ST_SORT_J;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                    if ((r_i + CW'(1)) < r_n) begin
                        n_i = r_i + CW'(1); n_state = ST_SORT_RD;
                    end else n_state = ST_DED_START;
                end
            end
            ST_DED_START: begin
                rwe = 1'b1; rwa = '0; rwd = r_org;
                n_m = CW'(1);
                if (r_cnt == '0) n_state = ST_SCAN_START;
                else begin
                    n_i = '0; n_oa = '0;
                    n_wc = 1'b0; n_ret = ST_DED_O; n_state = ST_WAIT;
                end
            end
            ST_DED_O: begin
                n_pa = r_oq;
                n_wc = 1'b0; n_ret = ST_DED_U; n_state = ST_WAIT;
            end
            ST_DED_U: begin
                n_u = r_pq;
                n_state = ST_DED_LOOP;
            end
            ST_DED_LOOP: begin
                if ((r_i + CW'(1)) < r_cnt) begin
                    n_oa = AW'(r_i + CW'(1));
                    n_wc = 1'b0; n_ret = ST_DED_O2; n_state = ST_WAIT;
                end else begin
                    rwe = 1'b1;
                    n_m = r_m + CW'(1);
                    n_state = ST_SCAN_START;
                end
            end
            ST_DED_O2: begin
                n_pa = r_oq;
                n_wc = 1'b0; n_ret = ST_DED_V; n_state = ST_WAIT;
            end
            ST_DED_V: begin
                n_xo = r_org; n_xa = r_u; n_xb = r_pq; n_v = r_pq;
                n_wc = 1'b1; n_ret = ST_DED_CMP; n_state = ST_WAIT;
            end
            ST_DED_CMP: begin
                if (!w_turn.zero) begin
                    rwe = 1'b1;
                    n_m = r_m + CW'(1);
                end
                n_u = r_v;
                n_i = r_i + CW'(1);
                n_state = ST_DED_LOOP;
            end
            ST_SCAN_START: begin
                n_s = '0;
                if (r_m < CW'(2)) begin
                    n_i = '0; n_state = ST_EMIT_RD;
                end else begin
                    n_s = CW'(1); n_i = CW'(2); n_ra = AW'(1);
                    n_wc = 1'b0; n_ret = ST_SCAN_T; n_state = ST_WAIT;
                end
            end
            ST_SCAN_T: begin
                n_top = r_rq;
                n_state = ST_SCAN_NEXT;
            end
            ST_SCAN_NEXT: begin
                if (r_i < r_m) begin
                    n_ra = r_i[AW-1:0];
                    n_wc = 1'b0; n_ret = ST_SCAN_V; n_state = ST_WAIT;
                end else begin
                    n_i = '0; n_state = ST_EMIT_RD;
                end
            end
            ST_SCAN_V: begin
                n_v = r_rq;
                n_state = ST_SCAN_POP;
            end
            ST_SCAN_POP: begin
                if (r_s >= CW'(2)) begin
                    n_ra = AW'(r_s - CW'(1));
                    n_wc = 1'b0; n_ret = ST_SCAN_B; n_state = ST_WAIT;
                end else begin
                    rwe = 1'b1; rwa = AW'(r_s + CW'(1)); rwd = r_v;
                    n_s = r_s + CW'(1); n_top = r_v; n_i = r_i + CW'(1);
                    n_state = ST_SCAN_NEXT;
                end
            end
            ST_SCAN_B: begin
                n_below = r_rq;
                n_xo = r_rq; n_xa = r_top; n_xb = r_v;
                n_wc = 1'b1; n_ret = ST_SCAN_TST; n_state = ST_WAIT;
            end
            ST_SCAN_TST: begin
                if (w_turn.neg || w_turn.zero) begin
                    n_s = r_s - CW'(1); n_top = r_below;
                    n_state = ST_SCAN_POP;
                end else begin
                    rwe = 1'b1; rwa = AW'(r_s + CW'(1)); rwd = r_v;
                    n_s = r_s + CW'(1); n_top = r_v; n_i = r_i + CW'(1);
                    n_state = ST_SCAN_NEXT;
                end
            end
            ST_EMIT_RD: begin
                n_ra = r_i[AW-1:0];
                n_wc = 1'b0; n_ret = ST_EMIT_W; n_state = ST_WAIT;
            end
            ST_EMIT_W: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_out = '{hull_x: r_rq.x, hull_y: r_rq.y, hull_last: (r_i == r_s)};
                    if (r_i == r_s) begin
                        n_n = '0; n_state = ST_LOAD;
                    end else begin
                        n_i = r_i + CW'(1); n_state = ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ret   <= ST_LOAD;
            r_wc    <= 1'b0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_cnt   <= '0;
            r_m     <= '0;
            r_s     <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_wc    <= n_wc;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_cnt   <= n_cnt;
            r_m     <= n_m;
            r_s     <= n_s;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa <= n_pa; r_oa <= n_oa; r_ra <= n_ra; r_qi <= n_qi;
        r_org <= n_org; r_p <= n_p; r_u <= n_u; r_v <= n_v;
        r_top <= n_top; r_below <= n_below;
        r_xo <= n_xo; r_xa <= n_xa; r_xb <= n_xb;
        r_out <= n_out;
    end

endmodule

/* design/gsch_checker.sv */
// Port-level checks for graham_scan_convex_hull, bound to the top level.
// Uses gsch_pkg for the item types.
module gsch_checker import gsch_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    a_busy_after_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.final_point |=> o_in_stall)
        else $error("input taken right after final item");

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_reset_ready: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind graham_scan_convex_hull gsch_checker u_gsch_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_item  (i_in_item),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_item (o_out_item)
);
